// ===== rtl/mpd_pkg.sv =====
// ---------------------------------------------------------------------------
// mpd_pkg
// Shared types and constants for the motion progress detector.
// ---------------------------------------------------------------------------
package mpd_pkg;

   localparam int COORD_BITS = 24;
   localparam int TIME_BITS  = 63;
   localparam int FRAME_BITS = 16;
   localparam int EPOCH_BITS = 32;
   localparam int COUNT_BITS = 8;
   localparam int DIFF_BITS  = COORD_BITS + 1;
   localparam int DIST_BITS  = 2 * DIFF_BITS + 1;
   localparam int THR_BITS   = 16;
   localparam int SQ_BITS    = 2 * THR_BITS;
   localparam int CSR_IDX_BITS = 3;
   localparam int CSR_DATA_BITS = TIME_BITS;

   localparam logic OP_POSE  = 1'b0;
   localparam logic OP_CLEAR = 1'b1;

   localparam logic [CSR_IDX_BITS-1:0] CSR_MAX_GAP     = 3'd0;
   localparam logic [CSR_IDX_BITS-1:0] CSR_MAX_STALL   = 3'd1;
   localparam logic [CSR_IDX_BITS-1:0] CSR_HOLD        = 3'd2;
   localparam logic [CSR_IDX_BITS-1:0] CSR_MIN_STEP    = 3'd3;
   localparam logic [CSR_IDX_BITS-1:0] CSR_MIN_TRAVEL  = 3'd4;
   localparam logic [CSR_IDX_BITS-1:0] CSR_MIN_SAMPLES = 3'd5;

   localparam logic [TIME_BITS-1:0]  RST_MAX_GAP     = 63'd500000000;
   localparam logic [TIME_BITS-1:0]  RST_MAX_STALL   = 63'd1000000000;
   localparam logic [TIME_BITS-1:0]  RST_HOLD        = 63'd2000000000;
   localparam logic [SQ_BITS-1:0]    RST_STEP_SQ     = 32'd100;
   localparam logic [SQ_BITS-1:0]    RST_TRAVEL_SQ   = 32'd4000000;
   localparam logic [COUNT_BITS-1:0] RST_MIN_SAMPLES = 8'd3;

   typedef struct packed {
      logic                          operation;
      logic                          tracking_enabled;
      logic signed [COORD_BITS-1:0]  x_pos;
      logic signed [COORD_BITS-1:0]  y_pos;
      logic                          is_waiting;
      logic [TIME_BITS-1:0]          sample_time;
      logic [FRAME_BITS-1:0]         frame_tag;
   } req_type;

   typedef struct packed {
      logic [EPOCH_BITS-1:0] epoch_count;
      logic                  epoch_advanced;
      logic                  tracker_restarted;
      logic                  waiting_flag;
   } rsp_type;

endpackage

// ===== rtl/mpd_dist_sq.sv =====
// ---------------------------------------------------------------------------
// mpd_dist_sq
// Exact squared Euclidean distance between two signed grid points.
// ---------------------------------------------------------------------------
module mpd_dist_sq (
   input  logic signed [mpd_pkg::COORD_BITS-1:0] a_x,
   input  logic signed [mpd_pkg::COORD_BITS-1:0] a_y,
   input  logic signed [mpd_pkg::COORD_BITS-1:0] b_x,
   input  logic signed [mpd_pkg::COORD_BITS-1:0] b_y,
   output logic [mpd_pkg::DIST_BITS-1:0]         dist_sq
);

   logic signed [mpd_pkg::DIFF_BITS-1:0]   dx;
   logic signed [mpd_pkg::DIFF_BITS-1:0]   dy;
   logic [mpd_pkg::DIFF_BITS-1:0]          mag_x;
   logic [mpd_pkg::DIFF_BITS-1:0]          mag_y;
   logic [2*mpd_pkg::DIFF_BITS-1:0]        sq_x;
   logic [2*mpd_pkg::DIFF_BITS-1:0]        sq_y;

   assign dx = {a_x[mpd_pkg::COORD_BITS-1], a_x} - {b_x[mpd_pkg::COORD_BITS-1], b_x};
   assign dy = {a_y[mpd_pkg::COORD_BITS-1], a_y} - {b_y[mpd_pkg::COORD_BITS-1], b_y};

   assign mag_x = dx[mpd_pkg::DIFF_BITS-1] ? -dx : dx;
   assign mag_y = dy[mpd_pkg::DIFF_BITS-1] ? -dy : dy;

   assign sq_x = mag_x * mag_x;
   assign sq_y = mag_y * mag_y;

   assign dist_sq = {1'b0, sq_x} + {1'b0, sq_y};

endmodule

// ===== rtl/motion_progress_detector.sv =====
// ---------------------------------------------------------------------------
// motion_progress_detector
// Counts sustained net translation of timestamped pose samples as progress
// epochs; restarts the tracker on waits, time faults, stalls and frame changes.
//
//   channel  direction  handshake              payload
//   req      in         req_valid / req_stall  mpd_pkg::req_type
//   rsp      out        rsp_valid / rsp_stall  mpd_pkg::rsp_type
//   csr      in         csr_wr_en              csr_index, csr_wdata
//
// One transfer per cycle in each direction unless a stall holds it; a result
// passes through the input register, then the result register.
// Tracker state updates when a request moves into the result register.
// Reset is synchronous and takes effect at once; no clearing pass.
// req_stall rises only while a held request cannot move into a stalled result.
// ---------------------------------------------------------------------------
module motion_progress_detector (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  mpd_pkg::req_type                     req_data,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output mpd_pkg::rsp_type                     rsp_data,
   input  logic                                 csr_wr_en,
   input  logic [mpd_pkg::CSR_IDX_BITS-1:0]     csr_index,
   input  logic [mpd_pkg::CSR_DATA_BITS-1:0]    csr_wdata
);

   // configuration
   logic [mpd_pkg::TIME_BITS-1:0]  max_gap_ff, max_stall_ff, hold_ff;
   logic [mpd_pkg::SQ_BITS-1:0]    step_sq_ff, travel_sq_ff;
   logic [mpd_pkg::COUNT_BITS-1:0] min_samples_ff;
   logic [mpd_pkg::THR_BITS-1:0]   csr_thr;
   logic [mpd_pkg::SQ_BITS-1:0]    csr_thr_sq;

   // pipeline
   logic             in_valid_ff, in_valid_in;
   mpd_pkg::req_type in_ff;
   logic             rsp_valid_ff, rsp_valid_in;
   mpd_pkg::rsp_type rsp_ff, rsp_in;
   logic             pipe_move, accept, fire;

   // tracker state
   logic [mpd_pkg::FRAME_BITS-1:0]        last_frame_ff, last_frame_in;
   logic [mpd_pkg::TIME_BITS-1:0]         observed_ff, observed_in;
   logic [mpd_pkg::TIME_BITS-1:0]         anchor_time_ff, anchor_time_in;
   logic [mpd_pkg::TIME_BITS-1:0]         advance_time_ff, advance_time_in;
   logic signed [mpd_pkg::COORD_BITS-1:0] anchor_x_ff, anchor_x_in;
   logic signed [mpd_pkg::COORD_BITS-1:0] anchor_y_ff, anchor_y_in;
   logic signed [mpd_pkg::COORD_BITS-1:0] prev_x_ff, prev_x_in;
   logic signed [mpd_pkg::COORD_BITS-1:0] prev_y_ff, prev_y_in;
   logic [mpd_pkg::COUNT_BITS-1:0]        count_ff, count_in;
   logic [mpd_pkg::EPOCH_BITS-1:0]        epoch_ff, epoch_in;
   logic                                  waiting_ff, waiting_in;

   // evaluation
   logic [mpd_pkg::DIST_BITS-1:0]  dist_prev, dist_anchor;
   logic [mpd_pkg::TIME_BITS-1:0]  gap, since_adv, since_anchor;
   logic                           restart, stepped, hold_met;
   logic [mpd_pkg::COUNT_BITS-1:0] count_step;
   logic                           advanced, restarted;

   assign csr_thr    = csr_wdata[mpd_pkg::THR_BITS-1:0];
   assign csr_thr_sq = csr_thr * csr_thr;

   always_ff @(posedge clock) begin
      if (reset) begin
         max_gap_ff     <= mpd_pkg::RST_MAX_GAP;
         max_stall_ff   <= mpd_pkg::RST_MAX_STALL;
         hold_ff        <= mpd_pkg::RST_HOLD;
         step_sq_ff     <= mpd_pkg::RST_STEP_SQ;
         travel_sq_ff   <= mpd_pkg::RST_TRAVEL_SQ;
         min_samples_ff <= mpd_pkg::RST_MIN_SAMPLES;
      end else if (csr_wr_en) begin
         case (csr_index)
            mpd_pkg::CSR_MAX_GAP:     max_gap_ff     <= csr_wdata;
            mpd_pkg::CSR_MAX_STALL:   max_stall_ff   <= csr_wdata;
            mpd_pkg::CSR_HOLD:        hold_ff        <= csr_wdata;
            mpd_pkg::CSR_MIN_STEP:    step_sq_ff     <= csr_thr_sq;
            mpd_pkg::CSR_MIN_TRAVEL:  travel_sq_ff   <= csr_thr_sq;
            mpd_pkg::CSR_MIN_SAMPLES: min_samples_ff <= csr_wdata[mpd_pkg::COUNT_BITS-1:0];
            default: ;
         endcase
      end
   end

   // handshake
   assign pipe_move    = !(rsp_valid_ff && rsp_stall);
   assign req_stall    = in_valid_ff && !pipe_move;
   assign accept       = req_valid && !req_stall;
   assign fire         = in_valid_ff && pipe_move;
   assign in_valid_in  = accept ? 1'b1 : (pipe_move ? 1'b0 : in_valid_ff);
   assign rsp_valid_in = pipe_move ? in_valid_ff : rsp_valid_ff;
   assign rsp_valid    = rsp_valid_ff;
   assign rsp_data     = rsp_ff;

   mpd_dist_sq u_dist_prev (
      .a_x     (in_ff.x_pos),
      .a_y     (in_ff.y_pos),
      .b_x     (prev_x_ff),
      .b_y     (prev_y_ff),
      .dist_sq (dist_prev)
   );

   mpd_dist_sq u_dist_anchor (
      .a_x     (in_ff.x_pos),
      .a_y     (in_ff.y_pos),
      .b_x     (anchor_x_ff),
      .b_y     (anchor_y_ff),
      .dist_sq (dist_anchor)
   );

   assign gap          = in_ff.sample_time - observed_ff;
   assign since_adv    = in_ff.sample_time - advance_time_ff;
   assign since_anchor = in_ff.sample_time - anchor_time_ff;

   assign restart = in_ff.is_waiting || (observed_ff == '0)
                 || (in_ff.sample_time <= observed_ff) || (gap > max_gap_ff)
                 || (in_ff.sample_time < advance_time_ff) || (since_adv > max_stall_ff)
                 || (in_ff.frame_tag != last_frame_ff);

   assign stepped    = dist_prev >= mpd_pkg::DIST_BITS'(step_sq_ff);
   assign count_step = (stepped && count_ff != '1) ? count_ff + 1'b1 : count_ff;
   assign hold_met   = (in_ff.sample_time >= anchor_time_ff) && (since_anchor >= hold_ff)
                    && (dist_anchor >= mpd_pkg::DIST_BITS'(travel_sq_ff))
                    && (count_step >= min_samples_ff);

   always_comb begin
      last_frame_in   = last_frame_ff;
      observed_in     = observed_ff;
      anchor_time_in  = anchor_time_ff;
      advance_time_in = advance_time_ff;
      anchor_x_in     = anchor_x_ff;
      anchor_y_in     = anchor_y_ff;
      prev_x_in       = prev_x_ff;
      prev_y_in       = prev_y_ff;
      count_in        = count_ff;
      epoch_in        = epoch_ff;
      waiting_in      = waiting_ff;
      advanced        = 1'b0;
      restarted       = 1'b0;
      if (in_ff.operation == mpd_pkg::OP_CLEAR) begin
         observed_in     = '0;
         anchor_time_in  = '0;
         advance_time_in = '0;
         waiting_in      = 1'b0;
      end else if (in_ff.tracking_enabled) begin
         last_frame_in = in_ff.frame_tag;
         observed_in   = in_ff.sample_time;
         waiting_in    = in_ff.is_waiting;
         if (restart || hold_met) begin
            anchor_time_in  = in_ff.sample_time;
            advance_time_in = in_ff.sample_time;
            anchor_x_in     = in_ff.x_pos;
            anchor_y_in     = in_ff.y_pos;
            prev_x_in       = in_ff.x_pos;
            prev_y_in       = in_ff.y_pos;
            count_in        = '0;
            restarted       = restart;
            advanced        = !restart;
            if (!restart) begin
               epoch_in = epoch_ff + 1'b1;
            end
         end else if (stepped) begin
            count_in        = count_step;
            advance_time_in = in_ff.sample_time;
            prev_x_in       = in_ff.x_pos;
            prev_y_in       = in_ff.y_pos;
         end
      end
      rsp_in.epoch_count       = epoch_in;
      rsp_in.epoch_advanced    = advanced;
      rsp_in.tracker_restarted = restarted;
      rsp_in.waiting_flag      = waiting_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff     <= 1'b0;
         rsp_valid_ff    <= 1'b0;
         last_frame_ff   <= '0;
         observed_ff     <= '0;
         anchor_time_ff  <= '0;
         advance_time_ff <= '0;
         anchor_x_ff     <= '0;
         anchor_y_ff     <= '0;
         prev_x_ff       <= '0;
         prev_y_ff       <= '0;
         count_ff        <= '0;
         epoch_ff        <= '0;
         waiting_ff      <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         if (fire) begin
            last_frame_ff   <= last_frame_in;
            observed_ff     <= observed_in;
            anchor_time_ff  <= anchor_time_in;
            advance_time_ff <= advance_time_in;
            anchor_x_ff     <= anchor_x_in;
            anchor_y_ff     <= anchor_y_in;
            prev_x_ff       <= prev_x_in;
            prev_y_ff       <= prev_y_in;
            count_ff        <= count_in;
            epoch_ff        <= epoch_in;
            waiting_ff      <= waiting_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         in_ff <= req_data;
      end
      if (fire) begin
         rsp_ff <= rsp_in;
      end
   end

   // checks
   a_flags_exclusive: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> !(rsp_ff.epoch_advanced && rsp_ff.tracker_restarted))
      else $error("advance and restart flagged together");

   a_epoch_step: assert property (@(posedge clock) disable iff (reset)
      (fire && advanced) |=> (epoch_ff == $past(epoch_ff) + 1'b1))
      else $error("epoch did not step by one on advance");

   a_restart_clears_count: assert property (@(posedge clock) disable iff (reset)
      (fire && restarted) |=> (count_ff == '0 && anchor_time_ff == observed_ff))
      else $error("restart left stale tracker state");

   a_stall_needs_item: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (in_valid_ff && rsp_valid_ff))
      else $error("request stalled with nothing held");

endmodule
